>>> rtl/desks_pkg.sv
// Shared definitions for the DES key schedule core: permutation tables,
// rotation schedule, register map and the key-slot handoff type.
// No dependencies.
package desks_pkg;

    localparam int HalfW   = 28;
    localparam int CdW     = 2 * HalfW;
    localparam int KeyW    = 64;
    localparam int SubkeyW = 48;
    localparam int RoundW  = 5;
    localparam int StepW   = 4;
    localparam int AddrW   = 3;
    localparam int DataW   = 32;

    localparam logic [StepW-1:0]  LastStep   = 4'd15;
    localparam logic [RoundW-1:0] LastRound  = 5'd16;
    localparam logic [AddrW-1:0]  RegRevAddr = 3'd0;

    // Left-rotation amount per round, round 1 first.
    localparam logic [1:0] RotSched [16] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
    };

    localparam logic [6:0] Pc1Tab [CdW] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
        7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
        7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
        7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
        7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] Pc2Tab [SubkeyW] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,
        6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,
        6'd27, 6'd20, 6'd13, 6'd2,  6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Key handed from the input slot to the round generator.
    typedef struct packed {
        logic              valid;
        logic              rev;
        logic [HalfW-1:0]  c;
        logic [HalfW-1:0]  d;
    } t_key_slot;

    // PC-1: DES bit n (1-based, MSB first) sits at key[64-n]. Pure wiring.
    function automatic logic [CdW-1:0] pc1(input logic [KeyW-1:0] key);
        logic [CdW-1:0] r;
        r = '0;
        for (int i = 0; i < CdW; i++) begin
            r[CdW-1-i] = key[KeyW - int'(Pc1Tab[i])];
        end
        return r;
    endfunction

    // PC-2 over C:D. Pure wiring.
    function automatic logic [SubkeyW-1:0] pc2(input logic [CdW-1:0] cd);
        logic [SubkeyW-1:0] r;
        r = '0;
        for (int i = 0; i < SubkeyW; i++) begin
            r[SubkeyW-1-i] = cd[CdW - int'(Pc2Tab[i])];
        end
        return r;
    endfunction

    // Shift for step k of a run. Forward: round k+1's amount, left.
    // Reverse: none on the first step, then the amount of round 17-k, right.
    function automatic logic [1:0] shift_amt(input logic rev,
                                             input logic [StepW-1:0] k);
        logic [StepW-1:0] idx;
        logic [1:0]       r;
        idx = rev ? (StepW'(0) - k) : k;
        r   = RotSched[idx];
        if (rev && (k == '0)) begin
            r = 2'd0;
        end
        return r;
    endfunction

    function automatic logic [HalfW-1:0] rot28(input logic [HalfW-1:0] x,
                                               input logic rev,
                                               input logic [1:0] amt);
        logic [HalfW-1:0] r;
        case (amt)
            2'd1:    r = rev ? {x[0], x[HalfW-1:1]}     : {x[HalfW-2:0], x[HalfW-1]};
            2'd2:    r = rev ? {x[1:0], x[HalfW-1:2]}   : {x[HalfW-3:0], x[HalfW-1:HalfW-2]};
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/desks_apb_regs.sv
// APB-style configuration register file: holds reverse_order.
// Depends on desks_pkg.
module desks_apb_regs import desks_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output logic             o_reverse_order
);

    logic r_rev;
    logic n_rev;
    logic wr_en;

    // Word-granular decode: the byte offset within a word is ignored.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite &&
                    (paddr[AddrW-1:2] == RegRevAddr[AddrW-1:2]);

    always_comb begin
        n_rev = r_rev;
        if (wr_en) begin
            n_rev = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= 1'b0;
        end else begin
            r_rev <= n_rev;
        end
    end

    always_comb begin
        unique case (paddr[AddrW-1:2])
            RegRevAddr[AddrW-1:2]: prdata = {{(DataW-1){1'b0}}, r_rev};
            default:               prdata = '0;
        endcase
    end

    assign o_reverse_order = r_rev;

endmodule

>>> rtl/desks_key_slot.sv
// Input slot: registers one key after PC-1 along with the order bit.
// Depends on desks_pkg.
module desks_key_slot import desks_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [KeyW-1:0] i_key,
    input  logic            i_reverse_order,
    input  logic            i_take,
    output t_key_slot       o_slot
);

    logic             r_valid;
    logic             r_rev;
    logic [HalfW-1:0] r_c;
    logic [HalfW-1:0] r_d;
    logic             accept;
    logic [CdW-1:0]   cd;

    // Slot is free in the cycle after the generator picks it up.
    assign o_in_stall = r_valid;
    assign accept     = i_in_valid && !r_valid;
    assign cd         = pc1(i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rev <= i_reverse_order;
            r_c   <= cd[CdW-1:HalfW];
            r_d   <= cd[HalfW-1:0];
        end
    end

    assign o_slot = '{valid: r_valid, rev: r_rev, c: r_c, d: r_d};

endmodule

>>> rtl/desks_round_gen.sv
// Round generator: rotates C/D one round per cycle while the output is not
// stalled, PC-2 into the output register. Depends on desks_pkg.
module desks_round_gen import desks_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_key_slot          i_slot,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SubkeyW-1:0] o_subkey,
    output logic [RoundW-1:0]  o_round_number,
    output logic               o_last
);

    logic               r_busy;
    logic               r_rev;
    logic [StepW-1:0]   r_step;
    logic [HalfW-1:0]   r_c;
    logic [HalfW-1:0]   r_d;
    logic               r_ov;
    logic [SubkeyW-1:0] r_subkey;
    logic [RoundW-1:0]  r_round;
    logic               r_last;

    logic               out_free;
    logic               fire;
    logic               cur_rev;
    logic [StepW-1:0]   cur_k;
    logic [HalfW-1:0]   cur_c;
    logic [HalfW-1:0]   cur_d;
    logic [1:0]         amt;
    logic [HalfW-1:0]   n_c;
    logic [HalfW-1:0]   n_d;
    logic [RoundW-1:0]  n_round;

    assign out_free = !r_ov || !i_out_stall;
    assign fire     = out_free && (r_busy || i_slot.valid);
    assign o_take   = fire && !r_busy;

    always_comb begin
        cur_rev = r_busy ? r_rev  : i_slot.rev;
        cur_k   = r_busy ? r_step : '0;
        cur_c   = r_busy ? r_c    : i_slot.c;
        cur_d   = r_busy ? r_d    : i_slot.d;
        amt     = shift_amt(cur_rev, cur_k);
        n_c     = rot28(cur_c, cur_rev, amt);
        n_d     = rot28(cur_d, cur_rev, amt);
        n_round = cur_rev ? (LastRound - {1'b0, cur_k})
                          : ({1'b0, cur_k} + RoundW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (fire) begin
                r_busy <= (cur_k != LastStep);
                r_ov   <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rev    <= cur_rev;
            r_step   <= cur_k + StepW'(1);
            r_c      <= n_c;
            r_d      <= n_d;
            r_subkey <= pc2({n_c, n_d});
            r_round  <= n_round;
            r_last   <= (cur_k == LastStep);
        end
    end

    assign o_out_valid    = r_ov;
    assign o_subkey       = r_subkey;
    assign o_round_number = r_round;
    assign o_last         = r_last;

endmodule

>>> rtl/des_key_schedule_core.sv
// DES key schedule core, top level: config registers, input slot and
// round generator. Depends on desks_pkg and the desks_* submodules.
//
//  channel   direction  handshake               word
//  in        sink       i_in_valid/o_in_stall   i_key (64b)
//  out       source     o_out_valid/i_out_stall o_subkey, o_round_number, o_last
//  cfg       APB slave  psel/penable/pready     reverse_order at 0x0
//
// Each key yields sixteen subkey words, one per cycle while the output is
// not stalled, and the next key is taken as soon as a run ends when keys
// arrive steadily. The first word passes the input slot, which loads at the
// accepting edge, and then the generator output register. The round
// generator is the pacing unit.
// The input slot holds one key, so the next key is taken while the current
// run is still going; an output stall freezes the generator in place.
// Reset is synchronous, active low; it clears valids and reverse_order.
module des_key_schedule_core import desks_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [KeyW-1:0]    i_key,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SubkeyW-1:0] o_subkey,
    output logic [RoundW-1:0]  o_round_number,
    output logic               o_last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [AddrW-1:0]   paddr,
    input  logic [DataW-1:0]   pwdata,
    output logic [DataW-1:0]   prdata,
    output logic               pready
);

    logic      reverse_order;
    logic      take;
    t_key_slot slot;

    desks_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_reverse_order (reverse_order)
    );

    // Order bit is captured with the key and rides along for the whole run.
    desks_key_slot u_slot (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_key           (i_key),
        .i_reverse_order (reverse_order),
        .i_take          (take),
        .o_slot          (slot)
    );

    // Forward runs rotate left before each subkey; reverse runs emit K16
    // straight from PC-1 and then undo the left rotations one by one.
    desks_round_gen u_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_slot         (slot),
        .o_take         (take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_subkey       (o_subkey),
        .o_round_number (o_round_number),
        .o_last         (o_last)
    );

endmodule

>>> rtl/desks_checker.sv
// Port-level checker for des_key_schedule_core, bound to the top level.
// Depends on desks_pkg and des_key_schedule_core.
module desks_checker import desks_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [SubkeyW-1:0] o_subkey,
    input logic [RoundW-1:0]  o_round_number,
    input logic               o_last
);

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_round_number >= RoundW'(1)) && (o_round_number <= LastRound))
        else $error("round number out of range");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_round_number == LastRound ||
                                     o_round_number == RoundW'(1)))
        else $error("last word on a middle round");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
            (o_out_valid && (o_round_number == $past(o_round_number) + RoundW'(1) ||
                             o_round_number == $past(o_round_number) - RoundW'(1))))
        else $error("run broken or rounds out of sequence");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_subkey) && $stable(o_round_number) && $stable(o_last)))
        else $error("stalled word changed");

endmodule

bind des_key_schedule_core desks_checker u_desks_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_subkey       (o_subkey),
    .o_round_number (o_round_number),
    .o_last         (o_last)
);
